FILE: rtl/ncac_pkg.sv
// ----------------------------------------------------------------------------
// ncac_pkg
// Shared types and constants of the nearest-center assignment engine.
// ----------------------------------------------------------------------------
package ncac_pkg;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int ACC_W      = 35;
    localparam int WDIST_W    = 51;
    localparam int COST_W     = 64;
    localparam int DIMS_W     = 4;
    localparam int CENTERS_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // item operations
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERS = 2'd1;

    localparam logic [DIMS_W-1:0]    DIMS_RST    = 4'd8;
    localparam logic [CENTERS_W-1:0] CENTERS_RST = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WMUL,
        ST_WOUT
    } t_state;

    // sequencer to accumulator bank
    typedef struct packed {
        logic clear;
        logic issue;
    } t_acc_ctrl;

    // accumulator bank to sequencer
    typedef struct packed {
        logic s1_valid;
        logic busy;
    } t_acc_stat;

endpackage

FILE: rtl/ncac_mul.sv
// ----------------------------------------------------------------------------
// ncac_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ncac_mul
    import ncac_pkg::*;
#(
    parameter int A_W = 35,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= P_W'(i_a) * P_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/ncac_acc.sv
// ----------------------------------------------------------------------------
// ncac_acc
// Per-center squared distance accumulators: read, saturating add of the
// squared difference, write back, and running minimum over the sweep.
// ----------------------------------------------------------------------------
module ncac_acc
    import ncac_pkg::*;
#(
    parameter int MAX_CENTERS = 16,
    parameter int CIDX_W      = 4,
    parameter int PROD_W      = 51
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_ctrl         i_ctrl,
    input  logic [CIDX_W-1:0] i_idx,
    input  logic [PROD_W-1:0] i_prod,
    output t_acc_stat         o_stat,
    output logic [CIDX_W-1:0] o_best_idx,
    output logic [ACC_W-1:0]  o_best_d
);

    logic [ACC_W-1:0]       r_mem [MAX_CENTERS];
    logic [MAX_CENTERS-1:0] r_vld;
    logic [ACC_W-1:0]       r_rd;
    logic                   r_s1_v;
    logic                   r_s1_ok;
    logic [CIDX_W-1:0]      r_s1_idx;
    logic                   r_s2_v;
    logic [CIDX_W-1:0]      r_s2_idx;
    logic [ACC_W-1:0]       r_s2_acc;
    logic [CIDX_W-1:0]      r_best_idx;
    logic [ACC_W-1:0]       r_best_d;
    logic [PROD_W:0]        w_sum;
    logic [ACC_W-1:0]       w_acc_new;
    logic                   w_better;

    // saturating add of the squared difference
    assign w_sum     = (PROD_W+1)'(r_s2_acc) + (PROD_W+1)'(i_prod);
    assign w_acc_new = (|w_sum[PROD_W:ACC_W]) ? {ACC_W{1'b1}} : w_sum[ACC_W-1:0];
    // sweep runs from center 0 upward, strict compare keeps the lowest index
    assign w_better  = (r_s2_idx == '0) || (w_acc_new < r_best_d);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_rd <= r_mem[i_idx];
        end
        if (r_s2_v) begin
            r_mem[r_s2_idx] <= w_acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_s1_v <= i_ctrl.issue;
            r_s2_v <= r_s1_v;
            // an entry that is not valid reads as zero
            if (i_ctrl.clear) begin
                r_vld <= '0;
            end else if (r_s2_v) begin
                r_vld[r_s2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_s1_ok  <= r_vld[i_idx];
        r_s2_idx <= r_s1_idx;
        r_s2_acc <= r_s1_ok ? r_rd : '0;
        if (r_s2_v && w_better) begin
            r_best_idx <= r_s2_idx;
            r_best_d   <= w_acc_new;
        end
    end

    assign o_stat.s1_valid = r_s1_v;
    assign o_stat.busy     = r_s1_v | r_s2_v;
    assign o_best_idx      = r_best_idx;
    assign o_best_d        = r_best_d;

`ifndef SYNTHESIS
    a_clear_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |-> !r_s1_v && !r_s2_v)
        else $error("accumulators cleared with a sweep in flight");

    a_consecutive_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s2_v |-> r_s1_idx == CIDX_W'(r_s2_idx + 1'b1))
        else $error("accumulator sweep skipped a center");

    a_first_is_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && (r_s2_idx == '0) |=> r_best_idx == '0)
        else $error("running minimum not restarted at center zero");

    a_written_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !i_ctrl.clear |=> r_vld[$past(r_s2_idx)])
        else $error("written accumulator not marked valid");
`endif

endmodule

FILE: rtl/nearest_center_assignment_cost.sv
// ----------------------------------------------------------------------------
// nearest_center_assignment_cost
// K-means assignment engine: nearest center, weighted distance, total cost.
// ----------------------------------------------------------------------------
// Center coordinates are loaded one item at a time; a point arrives one
// coordinate per item. Each point coordinate sweeps all centers in use
// through one shared multiplier, one center per cycle, and the block stalls
// its input until the sweep has drained; the point's last coordinate adds
// the weight multiply and the cost update through the same multiplier.
// Clear and load items do not stall the input. A finished result sits in
// the output register while the next item is accepted; a new result waits
// for that register to empty.
module nearest_center_assignment_cost
    import ncac_pkg::*;
#(
    parameter int MAX_DIMS    = 8,
    parameter int MAX_CENTERS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_cfg_valid,
    output logic                                             o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                            i_cfg_data,
    input  logic                                             i_in_valid,
    output logic                                             o_in_stall,
    input  logic [OP_W-1:0]                                  i_op,
    input  logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] i_center_index,
    input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0]       i_dim_index,
    input  logic signed [COORD_W-1:0]                        i_coord,
    input  logic [WEIGHT_W-1:0]                              i_weight,
    output logic                                             o_out_valid,
    input  logic                                             i_out_stall,
    output logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] o_nearest_index,
    output logic [ACC_W-1:0]                                 o_min_distance,
    output logic [WDIST_W-1:0]                               o_weighted_distance,
    output logic [COST_W-1:0]                                o_total_cost
);

    localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W  = $clog2(MAX_CENTERS + 1);
    localparam int DEPTH  = MAX_CENTERS * MAX_DIMS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
    localparam int MB_W   = (COORD_BITS > WEIGHT_W) ? COORD_BITS : WEIGHT_W;
    localparam int PROD_W = ACC_W + MB_W;

    t_state r_state;
    t_state n_state;

    logic [DIMS_W-1:0]           r_dims;
    logic [CENTERS_W-1:0]        r_centers;
    logic signed [COORD_BITS-1:0] r_store [DEPTH];
    logic signed [COORD_BITS-1:0] r_store_rd;
    logic signed [COORD_BITS-1:0] r_coord;
    logic [DIDX_W-1:0]           r_dim;
    logic [WEIGHT_W-1:0]         r_weight;
    logic                        r_last;
    logic [CNT_W-1:0]            r_nc;
    logic [CNT_W-1:0]            r_cnt;
    logic [COST_W-1:0]           r_cost;
    logic                        r_out_valid;
    logic [CIDX_W-1:0]           r_out_idx;
    logic [ACC_W-1:0]            r_out_min;
    logic [WDIST_W-1:0]          r_out_wd;
    logic [COST_W-1:0]           r_out_total;

    logic                        w_in_acc;
    logic                        w_dim_ok;
    logic                        w_point;
    logic                        w_load_we;
    logic                        w_issue;
    logic                        w_out_load;
    logic                        w_mul_en;
    logic [DIMS_W-1:0]           w_nd;
    logic [CNT_W-1:0]            w_nc;
    logic [EXT_W-1:0]            w_coord_ext;
    logic signed [COORD_BITS-1:0] w_coord;
    logic [ADDR_W-1:0]           w_wr_addr;
    logic [ADDR_W-1:0]           w_rd_addr;
    logic signed [COORD_BITS:0]  w_diff;
    logic [COORD_BITS:0]         w_neg;
    logic [COORD_BITS-1:0]       w_mag;
    logic [ACC_W-1:0]            w_mul_a;
    logic [MB_W-1:0]             w_mul_b;
    logic [PROD_W-1:0]           w_prod;
    logic [WDIST_W-1:0]          w_wd;
    logic [COST_W:0]             w_total_sum;
    logic [COST_W-1:0]           w_total_new;
    t_acc_ctrl                   w_acc_ctrl;
    t_acc_stat                   w_acc_stat;
    logic [CIDX_W-1:0]           w_best_idx;
    logic [ACC_W-1:0]            w_best_d;

    // effective register values
    always_comb begin
        if (r_dims == '0) begin
            w_nd = DIMS_W'(1);
        end else if (int'(r_dims) > MAX_DIMS) begin
            w_nd = DIMS_W'(MAX_DIMS);
        end else begin
            w_nd = r_dims;
        end
        if (r_centers == '0) begin
            w_nc = CNT_W'(1);
        end else if (int'(r_centers) > MAX_CENTERS) begin
            w_nc = CNT_W'(MAX_CENTERS);
        end else begin
            w_nc = CNT_W'(r_centers);
        end
    end

    // coordinate taken from the low COORD_BITS of the field
    assign w_coord_ext = EXT_W'($unsigned(i_coord));
    assign w_coord     = signed'(w_coord_ext[COORD_BITS-1:0]);

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_dim_ok   = int'(i_dim_index) < int'(w_nd);
    assign w_point    = w_in_acc && (i_op == OP_POINT) && w_dim_ok;
    assign w_load_we  = w_in_acc && (i_op == OP_LOAD)
                        && (int'(i_center_index) < MAX_CENTERS)
                        && (int'(i_dim_index) < MAX_DIMS);

    assign w_wr_addr = ADDR_W'(int'(i_center_index) * MAX_DIMS + int'(i_dim_index));
    assign w_rd_addr = ADDR_W'(int'(r_cnt[CIDX_W-1:0]) * MAX_DIMS + int'(r_dim));

    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_store[w_wr_addr] <= w_coord;
        end
        if (w_issue) begin
            r_store_rd <= r_store[w_rd_addr];
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_point) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                w_issue = (r_cnt < r_nc);
                // the last write back lands on the leaving edge
                if (!w_issue && !w_acc_stat.s1_valid) begin
                    n_state = r_last ? ST_WMUL : ST_IDLE;
                end
            end
            ST_WMUL: begin
                n_state = ST_WOUT;
            end
            ST_WOUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_acc_ctrl.clear = w_point && (i_dim_index == '0);
    assign w_acc_ctrl.issue = w_issue;

    // |coord - center| for the center read last cycle
    assign w_diff = (COORD_BITS+1)'(r_coord) - (COORD_BITS+1)'(r_store_rd);
    assign w_neg  = $unsigned(-w_diff);
    assign w_mag  = w_diff[COORD_BITS] ? w_neg[COORD_BITS-1:0] : w_diff[COORD_BITS-1:0];

    assign w_mul_en = w_acc_stat.s1_valid || (r_state == ST_WMUL);
    assign w_mul_a  = (r_state == ST_WMUL) ? w_best_d : ACC_W'(w_mag);
    assign w_mul_b  = (r_state == ST_WMUL) ? MB_W'(r_weight) : MB_W'(w_mag);

    ncac_mul #(
        .A_W (ACC_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    ncac_acc #(
        .MAX_CENTERS (MAX_CENTERS),
        .CIDX_W      (CIDX_W),
        .PROD_W      (PROD_W)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_acc_ctrl),
        .i_idx      (r_cnt[CIDX_W-1:0]),
        .i_prod     (w_prod),
        .o_stat     (w_acc_stat),
        .o_best_idx (w_best_idx),
        .o_best_d   (w_best_d)
    );

    assign w_wd        = w_prod[WDIST_W-1:0];
    assign w_total_sum = (COST_W+1)'(r_cost) + (COST_W+1)'(w_wd);
    assign w_total_new = w_total_sum[COST_W] ? {COST_W{1'b1}} : w_total_sum[COST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dims      <= DIMS_RST;
            r_centers   <= CENTERS_RST;
            r_cost      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DIMS:    r_dims    <= i_cfg_data[DIMS_W-1:0];
                    CFG_CENTERS: r_centers <= i_cfg_data[CENTERS_W-1:0];
                    default:     ;
                endcase
            end
            if (w_out_load) begin
                r_cost <= w_total_new;
            end else if (w_in_acc && (i_op == OP_CLEAR)) begin
                r_cost <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_point) begin
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_point) begin
            r_coord  <= w_coord;
            r_dim    <= i_dim_index;
            r_weight <= i_weight;
            r_last   <= int'(i_dim_index) == int'(w_nd) - 1;
            r_nc     <= w_nc;
        end
        if (w_out_load) begin
            r_out_idx   <= w_best_idx;
            r_out_min   <= w_best_d;
            r_out_wd    <= w_wd;
            r_out_total <= w_total_new;
        end
    end

    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_nearest_index     = r_out_idx;
    assign o_min_distance      = r_out_min;
    assign o_weighted_distance = r_out_wd;
    assign o_total_cost        = r_out_total;

`ifndef SYNTHESIS
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) && (n_state != ST_SWEEP) |-> r_cnt == r_nc)
        else $error("sweep left before all centers were visited");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_acc_stat.busy)
        else $error("accumulator pipeline busy while idle");

    a_cost_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_cost >= $past(r_cost))
        else $error("total cost decreased on a result");

    a_load_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_we |-> (r_state == ST_IDLE) && !w_acc_stat.busy)
        else $error("center store written during a sweep");
`endif

endmodule
